// ----- rtl/ssd_pkg.sv -----
// Shared constants and types for the segment-to-segment distance unit.
package ssd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int FIELD_W        = COORD_BITS_DEF;
  localparam int NUM_FIELDS     = 8;
  localparam int IN_TDATA_W     = FIELD_W * NUM_FIELDS;
  localparam int DIST_W         = 25;
  localparam int OUT_TDATA_W    = 32;
  localparam int NUM_CAND       = 4;

  // Per-candidate flags feeding the touch test.
  typedef struct packed {
    logic cz;     // cross product is zero
    logic cpos;   // cross product is positive
    logic cneg;   // cross product is negative
    logic inbox;  // point lies in the segment's bounding box
  } ssd_flags_t;

endpackage

// ----- rtl/ssd_front.sv -----
// Geometry front end for one point-to-segment candidate: squared distance as num/den.
module ssd_front #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssd_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [COORD_BITS-1:0]          px,
  input  logic signed [COORD_BITS-1:0]          py,
  input  logic signed [COORD_BITS-1:0]          ax,
  input  logic signed [COORD_BITS-1:0]          ay,
  input  logic signed [COORD_BITS-1:0]          bx,
  input  logic signed [COORD_BITS-1:0]          by,
  output ssd_pkg::ssd_flags_t                   flags,
  output logic [4*COORD_BITS+2+2*FRAC_BITS-1:0] num,
  output logic [2*COORD_BITS:0]                 den
);

  localparam int DB = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int LB = 2 * COORD_BITS + 1;
  localparam int MB = 2 * COORD_BITS + 1;
  localparam int NB = 4 * COORD_BITS + 2 + 2 * FRAC_BITS;

  logic signed [DB-1:0] vx, vy, wx, wy, ux, uy;
  logic signed [PW-1:0] len2_s, dotw_s, dotu_s, c_s, d2w_s, d2u_s;
  logic [LB-1:0]        len2, d2w, d2u, len2_3, d2sel;
  logic signed [PW-1:0] dotw, dotu, c;
  logic                 inbox, ptsel;
  logic [MB-1:0]        mag;
  logic [2*MB-1:0]      sq;
  logic                 pt_w, pt_u;

  // Stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      vx <= DB'(bx) - DB'(ax);
      vy <= DB'(by) - DB'(ay);
      wx <= DB'(px) - DB'(ax);
      wy <= DB'(py) - DB'(ay);
      ux <= DB'(px) - DB'(bx);
      uy <= DB'(py) - DB'(by);
    end
  end

  assign len2_s = PW'(vx) * PW'(vx) + PW'(vy) * PW'(vy);
  assign dotw_s = PW'(wx) * PW'(vx) + PW'(wy) * PW'(vy);
  assign dotu_s = PW'(ux) * PW'(vx) + PW'(uy) * PW'(vy);
  assign c_s    = PW'(vx) * PW'(wy) - PW'(vy) * PW'(wx);
  assign d2w_s  = PW'(wx) * PW'(wx) + PW'(wy) * PW'(wy);
  assign d2u_s  = PW'(ux) * PW'(ux) + PW'(uy) * PW'(uy);

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      len2  <= LB'(len2_s);
      dotw  <= dotw_s;
      dotu  <= dotu_s;
      c     <= c_s;
      d2w   <= LB'(d2w_s);
      d2u   <= LB'(d2u_s);
      // point between the endpoints on each axis when w and u are not both positive or both negative
      inbox <= !((wx > 0 && ux > 0) || (wx < 0 && ux < 0)) &&
               !((wy > 0 && uy > 0) || (wy < 0 && uy < 0));
    end
  end

  assign pt_w = (len2 == '0) || (dotw < 0);
  assign pt_u = !pt_w && (dotu > 0);

  // Stage 3: pick endpoint or perpendicular
  always_ff @(posedge clk) begin
    if (en) begin
      ptsel       <= pt_w || pt_u;
      d2sel       <= pt_w ? d2w : d2u;
      mag         <= (c < 0) ? MB'(-c) : MB'(c);
      len2_3      <= len2;
      flags.cz    <= (c == '0);
      flags.cpos  <= (c > 0);
      flags.cneg  <= (c < 0);
      flags.inbox <= inbox;
    end
  end

  assign sq = (2*MB)'(mag) * (2*MB)'(mag);

  // Stage 4: numerator, scaled by twice the fraction bits, and denominator
  always_ff @(posedge clk) begin
    if (en) begin
      num <= ptsel ? (NB'(d2sel) << (2 * FRAC_BITS)) : (NB'(sq) << (2 * FRAC_BITS));
      den <= ptsel ? LB'(1) : len2_3;
    end
  end

endmodule

// ----- rtl/ssd_div_cell.sv -----
// One restoring-division cell: produces one quotient bit and hands on to the next cell.
module ssd_div_cell #(
  parameter int LB = 2 * ssd_pkg::COORD_BITS_DEF + 1,
  parameter int QB = 2 * ssd_pkg::COORD_BITS_DEF + 2 + 2 * ssd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [LB-1:0] rem_in,
  input  logic [QB-1:0] nq_in,
  input  logic [LB-1:0] den_in,
  output logic [LB-1:0] rem_out,
  output logic [QB-1:0] nq_out,
  output logic [LB-1:0] den_out
);

  logic [LB:0] r2;
  logic        ge;

  assign r2 = {rem_in, nq_in[QB-1]};
  assign ge = (r2 >= (LB+1)'(den_in));

  // numerator bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? LB'(r2 - (LB+1)'(den_in)) : LB'(r2);
      nq_out  <= {nq_in[QB-2:0], ge};
      den_out <= den_in;
    end
  end

endmodule

// ----- rtl/ssd_sqrt_cell.sv -----
// One integer square-root cell: takes two radicand bits and yields one root bit.
module ssd_sqrt_cell #(
  parameter int QB = 2 * ssd_pkg::COORD_BITS_DEF + 2 + 2 * ssd_pkg::FRAC_BITS_DEF,
  parameter int RB = ssd_pkg::COORD_BITS_DEF + 1 + ssd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RB:0]   rem_in,
  input  logic [QB-1:0] rad_in,
  input  logic [RB-1:0] root_in,
  output logic [RB:0]   rem_out,
  output logic [QB-1:0] rad_out,
  output logic [RB-1:0] root_out
);

  logic [RB+2:0] r2, trial;
  logic          ge;

  assign r2    = {rem_in, rad_in[QB-1:QB-2]};
  assign trial = (RB+3)'({root_in, 2'b01});
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? (RB+1)'(r2 - trial) : (RB+1)'(r2);
      rad_out  <= {rad_in[QB-3:0], 2'b00};
      root_out <= {root_in[RB-2:0], ge};
    end
  end

endmodule

// ----- rtl/segment_segment_distance_unit.sv -----
// Top level: distance between two 2D segments, pipelined through rows of cells.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tdata: a_sx, a_sy, a_ex, a_ey, b_sx, b_sy, b_ex, b_ey
//  m_*       out  tvalid / tready    tdata: distance_fixed; tuser: segments_touch
//
// One item per cycle enters and leaves while the pipeline advances; items pass the front-end
// stages, QB = 2*COORD_BITS+2+2*FRAC_BITS division cells, the minimum stages,
// RB = COORD_BITS+1+FRAC_BITS root cells (50 and 25 at the defaults) and the output register.
// The whole pipeline advances together whenever the output register is empty or taken.
// rst clears only the stage valid bits.
module segment_segment_distance_unit #(
  parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssd_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // low to high: a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]          s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // low to high: distance_fixed (25), zero fill
  output logic [ssd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // segments_touch
  output logic                             m_tuser
);

  localparam int C  = COORD_BITS;
  localparam int LB = 2 * C + 1;
  localparam int NB = 4 * C + 2 + 2 * FRAC_BITS;
  localparam int QB = 2 * C + 2 + 2 * FRAC_BITS;
  localparam int RB = C + 1 + FRAC_BITS;
  localparam int SM = 4 + QB + 2;      // stage of the final minimum
  localparam int L  = SM + RB + 1;     // output register stage
  localparam int FW = C;
  localparam int NC = ssd_pkg::NUM_CAND;

  logic                ce;
  logic [L:1]          vld;
  logic [L:4]          tch;
  logic signed [C-1:0] crd [8];
  logic                touch;

  ssd_pkg::ssd_flags_t flg [NC];
  logic [NB-1:0]       num [NC];
  logic [LB-1:0]       den [NC];

  logic [LB-1:0]       drem [NC][QB+1];
  logic [QB-1:0]       dnq  [NC][QB+1];
  logic [LB-1:0]       dden [NC][QB+1];

  logic [QB-1:0]       m01, m23, mfin;
  logic [RB:0]         srem  [RB+1];
  logic [QB-1:0]       srad  [RB+1];
  logic [RB-1:0]       sroot [RB+1];
  logic [ssd_pkg::DIST_W-1:0] dist_q;

  assign ce       = !vld[L] || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[L];
  assign m_tuser  = tch[L];
  assign m_tdata  = ssd_pkg::OUT_TDATA_W'(dist_q);

  for (genvar i = 0; i < 8; i++) begin : g_crd
    assign crd[i] = $signed(s_tdata[i*FW +: FW]);
  end

  // Candidates: B start and B end against A, A start and A end against B
  ssd_front #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_front0 (
    .clk, .en(ce), .px(crd[4]), .py(crd[5]), .ax(crd[0]), .ay(crd[1]),
    .bx(crd[2]), .by(crd[3]), .flags(flg[0]), .num(num[0]), .den(den[0]));
  ssd_front #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_front1 (
    .clk, .en(ce), .px(crd[6]), .py(crd[7]), .ax(crd[0]), .ay(crd[1]),
    .bx(crd[2]), .by(crd[3]), .flags(flg[1]), .num(num[1]), .den(den[1]));
  ssd_front #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_front2 (
    .clk, .en(ce), .px(crd[0]), .py(crd[1]), .ax(crd[4]), .ay(crd[5]),
    .bx(crd[6]), .by(crd[7]), .flags(flg[2]), .num(num[2]), .den(den[2]));
  ssd_front #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_front3 (
    .clk, .en(ce), .px(crd[2]), .py(crd[3]), .ax(crd[4]), .ay(crd[5]),
    .bx(crd[6]), .by(crd[7]), .flags(flg[3]), .num(num[3]), .den(den[3]));

  // Proper crossing, or any endpoint lying on the other segment
  assign touch =
    (((flg[2].cpos && flg[3].cneg) || (flg[2].cneg && flg[3].cpos)) &&
     ((flg[0].cpos && flg[1].cneg) || (flg[0].cneg && flg[1].cpos))) ||
    (flg[0].cz && flg[0].inbox) || (flg[1].cz && flg[1].inbox) ||
    (flg[2].cz && flg[2].inbox) || (flg[3].cz && flg[3].inbox);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[L-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tch <= {tch[L-1:4], touch};
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_div
    assign drem[k][0] = LB'(num[k][NB-1:QB]);
    assign dnq[k][0]  = num[k][QB-1:0];
    assign dden[k][0] = den[k];
    for (genvar j = 0; j < QB; j++) begin : g_cell
      ssd_div_cell #(.LB(LB), .QB(QB)) u_cell (
        .clk, .en(ce),
        .rem_in(drem[k][j]), .nq_in(dnq[k][j]), .den_in(dden[k][j]),
        .rem_out(drem[k][j+1]), .nq_out(dnq[k][j+1]), .den_out(dden[k][j+1]));
    end
  end

  // Minimum of the four quotients; a touching pair drops to zero
  always_ff @(posedge clk) begin
    if (ce) begin
      m01  <= (dnq[0][QB] < dnq[1][QB]) ? dnq[0][QB] : dnq[1][QB];
      m23  <= (dnq[2][QB] < dnq[3][QB]) ? dnq[2][QB] : dnq[3][QB];
      mfin <= tch[SM-1] ? '0 : ((m01 < m23) ? m01 : m23);
    end
  end

  assign srem[0]  = '0;
  assign srad[0]  = mfin;
  assign sroot[0] = '0;
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    ssd_sqrt_cell #(.QB(QB), .RB(RB)) u_cell (
      .clk, .en(ce),
      .rem_in(srem[j]), .rad_in(srad[j]), .root_in(sroot[j]),
      .rem_out(srem[j+1]), .rad_out(srad[j+1]), .root_out(sroot[j+1]));
  end

  // Output register: hold while the item waits
  always_ff @(posedge clk) begin
    if (ce) begin
      dist_q <= ssd_pkg::DIST_W'(sroot[RB]);
    end
  end

endmodule

// ----- rtl/ssd_checker.sv -----
// Port-level checks for the segment distance unit, bound to the top level.
module ssd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  a_touch_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[ssd_pkg::DIST_W-1:0] == '0))
    else $error("touching item with nonzero distance");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ssd_pkg::OUT_TDATA_W-1:ssd_pkg::DIST_W] == '0))
    else $error("tdata fill bits not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output item changed");

endmodule

bind segment_segment_distance_unit ssd_checker u_ssd_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));

// ----- tb/tb.sv -----
// Testbench for segment_segment_distance_unit: random and directed segment pairs.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ssd_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ssd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  typedef struct {
    logic [ssd_pkg::DIST_W-1:0] gap_fixed;
    logic touch;
  } gap_result_t;

  logic [ssd_pkg::IN_TDATA_W-1:0] pair_queue[$];
  gap_result_t gap_expected[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  int send_wait = 0;
  int take_wait = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  segment_segment_distance_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // floor(2^FRAC * sqrt(num / den))
  function automatic longint unsigned root_of_ratio(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] t;
    q = (num << (2 * ssd_pkg::FRAC_BITS_DEF)) / den;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= q) r = t;
    end
    return r[63:0];
  endfunction

  function automatic longint unsigned point_gap(longint dx, longint dy);
    return root_of_ratio(128'(dx * dx + dy * dy), 128'd1);
  endfunction

  function automatic longint unsigned point_to_seg(longint px, longint py, longint ax,
                                                   longint ay, longint bx, longint by);
    longint vx, vy, wx, wy, ux, uy, len2, c;
    logic [127:0] mag;
    vx = bx - ax; vy = by - ay;
    wx = px - ax; wy = py - ay;
    ux = px - bx; uy = py - by;
    len2 = vx * vx + vy * vy;
    if (len2 == 0 || wx * vx + wy * vy < 0) return point_gap(wx, wy);
    if (ux * vx + uy * vy > 0) return point_gap(ux, uy);
    c = vx * wy - vy * wx;
    if (c < 0) c = -c;
    mag = 128'(c);
    return root_of_ratio(mag * mag, 128'(len2));
  endfunction

  function automatic longint turn(longint ox, longint oy, longint ax, longint ay,
                                  longint bx, longint by);
    return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
  endfunction

  function automatic bit within_box(longint ax, longint ay, longint bx, longint by,
                                    longint px, longint py);
    return px >= (ax < bx ? ax : bx) && px <= (ax < bx ? bx : ax) &&
           py >= (ay < by ? ay : by) && py <= (ay < by ? by : ay);
  endfunction

  function automatic gap_result_t predict_gap(logic [ssd_pkg::IN_TDATA_W-1:0] d);
    longint p[8];
    longint d1, d2, d3, d4;
    longint unsigned best, t;
    gap_result_t res;
    for (int i = 0; i < 8; i++)
      p[i] = longint'($signed(d[ssd_pkg::FIELD_W*i +: ssd_pkg::FIELD_W]));
    d1 = turn(p[4], p[5], p[6], p[7], p[0], p[1]);
    d2 = turn(p[4], p[5], p[6], p[7], p[2], p[3]);
    d3 = turn(p[0], p[1], p[2], p[3], p[4], p[5]);
    d4 = turn(p[0], p[1], p[2], p[3], p[6], p[7]);
    res.touch = (((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)) &&
                 ((d3 > 0 && d4 < 0) || (d3 < 0 && d4 > 0))) ||
                (d1 == 0 && within_box(p[4], p[5], p[6], p[7], p[0], p[1])) ||
                (d2 == 0 && within_box(p[4], p[5], p[6], p[7], p[2], p[3])) ||
                (d3 == 0 && within_box(p[0], p[1], p[2], p[3], p[4], p[5])) ||
                (d4 == 0 && within_box(p[0], p[1], p[2], p[3], p[6], p[7]));
    best = 0;
    if (!res.touch) begin
      best = point_to_seg(p[4], p[5], p[0], p[1], p[2], p[3]);
      t = point_to_seg(p[6], p[7], p[0], p[1], p[2], p[3]);
      if (t < best) best = t;
      t = point_to_seg(p[0], p[1], p[4], p[5], p[6], p[7]);
      if (t < best) best = t;
      t = point_to_seg(p[2], p[3], p[4], p[5], p[6], p[7]);
      if (t < best) best = t;
    end
    res.gap_fixed = best[ssd_pkg::DIST_W-1:0];
    return res;
  endfunction

  function automatic logic [ssd_pkg::IN_TDATA_W-1:0] pack_pair(int ax, int ay, int bx, int by,
                                                               int cx, int cy, int ex, int ey);
    return {16'(ey), 16'(ex), 16'(cy), 16'(cx), 16'(by), 16'(bx), 16'(ay), 16'(ax)};
  endfunction

  // append one item to the pending queue
  task automatic add_pair(logic [ssd_pkg::IN_TDATA_W-1:0] v);
    pair_queue = {pair_queue, v};
  endtask

  function automatic int coord(int mode);
    case (mode)
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 12) - 6;
      2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                     : -32768 + $urandom_range(0, 3);
      default: return $urandom_range(0, 400) - 200;
    endcase
  endfunction

  // sender: hold while stalled, otherwise wait out the gap then present the next item
  always @(posedge clk) begin
    bit taken;
    taken = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (taken) begin
        gap_expected = {gap_expected, predict_gap(s_tdata)};
        if ($urandom_range(0, 60) == 0) send_burst = ~send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (s_tvalid && !taken) begin
        // hold the item
      end else if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        s_tdata <= pair_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    gap_result_t exp_res;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (gap_expected.size() == 0) begin
          $error("unexpected item: distance_fixed %0d", m_tdata[ssd_pkg::DIST_W-1:0]);
          errors++;
        end else begin
          exp_res = gap_expected.pop_front();
          if (m_tdata[ssd_pkg::DIST_W-1:0] !== exp_res.gap_fixed) begin
            $error("distance_fixed: expected %0d, got %0d", exp_res.gap_fixed,
                   m_tdata[ssd_pkg::DIST_W-1:0]);
            errors++;
          end
          if (m_tuser !== exp_res.touch) begin
            $error("segments_touch: expected %0d, got %0d", exp_res.touch, m_tuser);
            errors++;
          end
        end
        if ($urandom_range(0, 60) == 0) take_burst = ~take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, 9);
      end
      if (take_wait > 0) begin
        take_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int m;
    // extremes, crossings, endpoint contact, collinear overlap and gap, point segments
    add_pair(pack_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
    add_pair(pack_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768));
    add_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    add_pair(pack_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
    add_pair(pack_pair(0, 0, 10, 0, 10, 0, 10, 10));
    add_pair(pack_pair(0, 0, 10, 0, 5, 0, 5, 7));
    add_pair(pack_pair(0, 0, 10, 0, 5, 0, 20, 0));
    add_pair(pack_pair(0, 0, 10, 0, 11, 0, 20, 0));
    add_pair(pack_pair(0, 0, 10, 10, 3, 3, 7, 7));
    add_pair(pack_pair(3, 4, 3, 4, 3, 4, 3, 4));
    add_pair(pack_pair(3, 4, 3, 4, 0, 0, 0, 0));
    add_pair(pack_pair(5, 5, 5, 5, 0, 0, 10, 10));
    add_pair(pack_pair(5, 6, 5, 6, 0, 0, 10, 10));
    add_pair(pack_pair(0, 0, 0, 0, 1, 1, 9, 1));
    add_pair(pack_pair(0, 0, 32767, 32766, 1, 1, 1, 5));
    add_pair(pack_pair(0, 0, 10, 0, -5, 3, -1, 9));
    add_pair(pack_pair(0, 0, 10, 0, 15, 3, 20, 9));
    add_pair(pack_pair(0, 0, 10, 0, 3, 2, 7, 2));
    add_pair(pack_pair(32767, 0, -32768, 0, 0, 1, 0, 32767));
    add_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    for (int i = 0; i < 1030; i++) begin
      m = $urandom_range(0, 3);
      add_pair(pack_pair(coord(m), coord(m), coord(m), coord(m),
                         coord(m), coord(m), coord(m), coord(m)));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pair_queue.size() == 0 && !s_tvalid);
    wait (gap_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && gap_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
